### rtl/czmd_pkg.sv
// ----------------------------------------------------------------------------
// czmd_pkg
// Shared types and constants of the color zone motion detector.
// ----------------------------------------------------------------------------
package czmd_pkg;

  localparam int unsigned MAX_COLUMNS = 2048;
  localparam int unsigned COL_W       = $clog2(MAX_COLUMNS);
  localparam int unsigned FW_W        = COL_W + 1;
  localparam int unsigned CH_W        = 8;
  localparam int unsigned OUT_CNT_W   = 20;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HUE_CENTER  = 3'd0,
    CFG_SAT_CENTER  = 3'd1,
    CFG_VAL_CENTER  = 3'd2,
    CFG_TOLERANCE   = 3'd3,
    CFG_FRAME_WIDTH = 3'd4,
    CFG_HALF_WINDOW = 3'd5,
    CFG_MIN_COUNT   = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ZONE_MIDDLE = 2'd0,
    ZONE_LOW    = 2'd1,
    ZONE_HIGH   = 2'd2,
    ZONE_NONE   = 2'd3
  } zone_e;

  localparam logic [CH_W-1:0]      HUE_CENTER_RST  = 8'd10;
  localparam logic [CH_W-1:0]      SAT_CENTER_RST  = 8'd255;
  localparam logic [CH_W-1:0]      VAL_CENTER_RST  = 8'd255;
  localparam logic [CH_W-1:0]      TOLERANCE_RST   = 8'd100;
  localparam logic [FW_W-1:0]      FRAME_WIDTH_RST = 12'd640;
  localparam logic [COL_W-1:0]     HALF_WINDOW_RST = 11'd120;
  localparam logic [OUT_CNT_W-1:0] MIN_COUNT_RST   = 20'd100;

  typedef struct packed {
    logic [CH_W-1:0]      hue_center;
    logic [CH_W-1:0]      sat_center;
    logic [CH_W-1:0]      val_center;
    logic [CH_W-1:0]      tolerance;
    logic [FW_W-1:0]      frame_width;
    logic [COL_W-1:0]     half_window;
    logic [OUT_CNT_W-1:0] min_count;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0]  hue;
    logic [CH_W-1:0]  saturation;
    logic [CH_W-1:0]  brightness;
    logic [COL_W-1:0] column;
    logic             end_of_frame;
  } pix_in_t;

  typedef struct packed {
    logic                 mask_bit;
    logic                 frame_done;
    logic [1:0]           zone_position;
    logic                 position_changed;
    logic [OUT_CNT_W-1:0] middle_count;
    logic [OUT_CNT_W-1:0] low_count;
    logic [OUT_CNT_W-1:0] high_count;
  } res_out_t;

  typedef struct packed {
    logic mask;
    logic in_mid;
    logic in_low;
    logic in_high;
    logic eof;
  } cls_t;

endpackage

### rtl/czmd_cfg_regs.sv
// ----------------------------------------------------------------------------
// czmd_cfg_regs
// Configuration register file with reset values and a plain write port.
// ----------------------------------------------------------------------------
module czmd_cfg_regs
  import czmd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_HUE_CENTER:  cfg_d.hue_center  = cfg_wdata_i[CH_W-1:0];
        CFG_SAT_CENTER:  cfg_d.sat_center  = cfg_wdata_i[CH_W-1:0];
        CFG_VAL_CENTER:  cfg_d.val_center  = cfg_wdata_i[CH_W-1:0];
        CFG_TOLERANCE:   cfg_d.tolerance   = cfg_wdata_i[CH_W-1:0];
        CFG_FRAME_WIDTH: cfg_d.frame_width = cfg_wdata_i[FW_W-1:0];
        CFG_HALF_WINDOW: cfg_d.half_window = cfg_wdata_i[COL_W-1:0];
        CFG_MIN_COUNT:   cfg_d.min_count   = cfg_wdata_i[OUT_CNT_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hue_center  <= HUE_CENTER_RST;
      cfg_q.sat_center  <= SAT_CENTER_RST;
      cfg_q.val_center  <= VAL_CENTER_RST;
      cfg_q.tolerance   <= TOLERANCE_RST;
      cfg_q.frame_width <= FRAME_WIDTH_RST;
      cfg_q.half_window <= HALF_WINDOW_RST;
      cfg_q.min_count   <= MIN_COUNT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/czmd_classify.sv
// ----------------------------------------------------------------------------
// czmd_classify
// Input register and per-pixel color window and column zone decode.
// ----------------------------------------------------------------------------
module czmd_classify
  import czmd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  pix_in_t in_data_i,
  output logic    cls_valid_o,
  input  logic    cls_ready_i,
  output cls_t    cls_o
);

  logic    valid_d, valid_q;
  pix_in_t pix_q;
  logic    hue_ok, sat_ok, val_ok;
  logic [COL_W-1:0] half;
  logic [FW_W-1:0]  col_plus_h;
  logic [FW_W-1:0]  half_plus_h;
  logic             in_frame;

  assign in_ready_o = !valid_q || cls_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      pix_q <= in_data_i;
    end
  end

  // Window tests written without negative bounds: x + tol >= c and x <= c + tol.
  assign hue_ok = ({1'b0, pix_q.hue} + {1'b0, cfg_i.tolerance} >= {1'b0, cfg_i.hue_center})
               && ({1'b0, pix_q.hue} <= {1'b0, cfg_i.hue_center} + {1'b0, cfg_i.tolerance});
  assign sat_ok = ({1'b0, pix_q.saturation} + {1'b0, cfg_i.tolerance}
                   >= {1'b0, cfg_i.sat_center})
               && ({1'b0, pix_q.saturation} <= {1'b0, cfg_i.sat_center}
                   + {1'b0, cfg_i.tolerance});
  assign val_ok = ({1'b0, pix_q.brightness} + {1'b0, cfg_i.tolerance}
                   >= {1'b0, cfg_i.val_center})
               && ({1'b0, pix_q.brightness} <= {1'b0, cfg_i.val_center}
                   + {1'b0, cfg_i.tolerance});

  // Zone bounds compared as column + H against half, avoiding signed values.
  assign half        = cfg_i.frame_width[FW_W-1:1];
  assign col_plus_h  = {1'b0, pix_q.column} + {1'b0, cfg_i.half_window};
  assign half_plus_h = {1'b0, half} + {1'b0, cfg_i.half_window};
  assign in_frame    = {1'b0, pix_q.column} < cfg_i.frame_width;

  assign cls_valid_o    = valid_q;
  assign cls_o.mask     = hue_ok && sat_ok && val_ok;
  assign cls_o.in_mid   = in_frame && (col_plus_h >= {1'b0, half})
                          && ({1'b0, pix_q.column} < half_plus_h);
  assign cls_o.in_low   = in_frame && (col_plus_h <= {1'b0, half});
  assign cls_o.in_high  = in_frame && ({1'b0, pix_q.column} >= half_plus_h);
  assign cls_o.eof      = pix_q.end_of_frame;

endmodule

### rtl/czmd_tracker.sv
// ----------------------------------------------------------------------------
// czmd_tracker
// Zone hit counters, end of frame winner decision and result register.
// ----------------------------------------------------------------------------
module czmd_tracker
  import czmd_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     cls_valid_i,
  output logic     cls_ready_o,
  input  cls_t     cls_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output res_out_t out_data_o
);

  localparam int unsigned CW = (COUNT_BITS > OUT_CNT_W) ? COUNT_BITS : OUT_CNT_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic                  load;
  logic                  valid_d, valid_q;
  logic [COUNT_BITS-1:0] mid_d, mid_q, low_d, low_q, high_d, high_q;
  logic [COUNT_BITS-1:0] mid_n, low_n, high_n;
  logic [CW-1:0]         mid_x, low_x, high_x, min_x;
  zone_e                 held_d, held_q;
  zone_e                 win;
  logic                  changed;
  res_out_t              res_d, res_q;

  assign cls_ready_o = !valid_q || out_ready_i;
  assign load        = cls_valid_i && cls_ready_o;

  assign mid_n  = (cls_i.mask && cls_i.in_mid && mid_q != CNT_MAX) ?
                  mid_q + 1'b1 : mid_q;
  assign low_n  = (cls_i.mask && cls_i.in_low && low_q != CNT_MAX) ?
                  low_q + 1'b1 : low_q;
  assign high_n = (cls_i.mask && cls_i.in_high && high_q != CNT_MAX) ?
                  high_q + 1'b1 : high_q;

  assign mid_x  = CW'(mid_n);
  assign low_x  = CW'(low_n);
  assign high_x = CW'(high_n);
  assign min_x  = CW'(cfg_i.min_count);

  always_comb begin
    priority if (mid_x > low_x && mid_x > high_x && mid_x > min_x) begin
      win = ZONE_MIDDLE;
    end else if (low_x > mid_x && low_x > high_x && low_x > min_x) begin
      win = ZONE_LOW;
    end else if (high_x > mid_x && high_x > low_x && high_x > min_x) begin
      win = ZONE_HIGH;
    end else begin
      win = ZONE_NONE;
    end
  end

  assign changed = cls_i.eof && (win != ZONE_NONE) && (win != held_q);

  always_comb begin
    valid_d = valid_q;
    mid_d   = mid_q;
    low_d   = low_q;
    high_d  = high_q;
    held_d  = held_q;
    res_d   = res_q;
    if (cls_ready_o) begin
      valid_d = cls_valid_i;
    end
    if (load) begin
      res_d.mask_bit         = cls_i.mask;
      res_d.frame_done       = cls_i.eof;
      res_d.position_changed = changed;
      if (cls_i.eof) begin
        mid_d  = '0;
        low_d  = '0;
        high_d = '0;
        if (changed) begin
          held_d = win;
        end
        res_d.middle_count = mid_x[OUT_CNT_W-1:0];
        res_d.low_count    = low_x[OUT_CNT_W-1:0];
        res_d.high_count   = high_x[OUT_CNT_W-1:0];
      end else begin
        mid_d  = mid_n;
        low_d  = low_n;
        high_d = high_n;
        res_d.middle_count = '0;
        res_d.low_count    = '0;
        res_d.high_count   = '0;
      end
      res_d.zone_position = changed ? win : held_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      mid_q   <= '0;
      low_q   <= '0;
      high_q  <= '0;
      held_q  <= ZONE_NONE;
    end else begin
      valid_q <= valid_d;
      mid_q   <= mid_d;
      low_q   <= low_d;
      high_q  <= high_d;
      held_q  <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = res_q;

  a_clear_after_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && cls_i.eof |=> mid_q == '0 && low_q == '0 && high_q == '0)
    else $error("zone counters not cleared after end of frame");

  a_changed_has_zone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.position_changed |->
      out_data_o.zone_position != ZONE_NONE && out_data_o.frame_done)
    else $error("position change reported without a zone");

  a_quiet_mid_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.frame_done |->
      out_data_o.middle_count == '0 && out_data_o.low_count == '0 &&
      out_data_o.high_count == '0 && !out_data_o.position_changed)
    else $error("counts shown on a result that does not close a frame");

  a_held_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q != ZONE_NONE |=> held_q != ZONE_NONE)
    else $error("held position returned to none");

endmodule

### rtl/color_zone_motion_detector_unit.sv
// ----------------------------------------------------------------------------
// color_zone_motion_detector_unit
// Color window mask per HSV pixel, column zone hit counting and end of frame
// motion position tracking.
// ----------------------------------------------------------------------------
// A result passes the classify input register and then the tracker result register;
// back-pressure from out_ready_i can hold it in either.
// Throughput: one pixel per cycle while out_ready_i does not stall the result register,
// set by the input register and result register pair around a single combinational pass.
// Reset: configuration returns to its default values, zone counters clear and the
// held position reads as none.
module color_zone_motion_detector_unit
  import czmd_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pix_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output res_out_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t cfg;
  cls_t cls;
  logic cls_valid;
  logic cls_ready;

  czmd_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  czmd_classify u_classify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cls_valid_o (cls_valid),
    .cls_ready_i (cls_ready),
    .cls_o       (cls)
  );

  czmd_tracker #(
    .COUNT_BITS (COUNT_BITS)
  ) u_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cls_valid_i (cls_valid),
    .cls_ready_o (cls_ready),
    .cls_i       (cls),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
